// ===== design/pdrq_pkg.sv =====
`default_nettype none
package pdrq_pkg;

  // defaults for the top-level parameters
  localparam int DEF_QUEUE_DEPTH = 8;
  localparam int DEF_TIME_BITS   = 48;

  // payload size limit, at or above rejects
  localparam logic [15:0] PAYLOAD_LIMIT = 16'd768;

  // attempts allowed in one tick
  localparam int MAX_ATTEMPTS = 8;

  // backoff register: cap is below 2**20, one doubling past it fits
  localparam int BACKOFF_BITS = 21;
  localparam int TRIES_BITS   = 8;

  // register reset values
  localparam logic [15:0] BASE_RESET = 16'd1000;
  localparam logic [19:0] MAX_RESET  = 20'd30000;

  // register indexes
  localparam logic REG_BASE = 1'b0;
  localparam logic REG_MAX  = 1'b1;

  // result status codes
  localparam logic [2:0] ST_DIRECT    = 3'd0;
  localparam logic [2:0] ST_QUEUED    = 3'd1;
  localparam logic [2:0] ST_EVICTED   = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_INVALID   = 3'd5;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EVICT,
    S_APPEND,
    S_TICK,
    S_BACKOFF,
    S_FLUSH
  } state_t;

  // per-cell load controls
  typedef struct packed {
    logic shift;      // take the neighbor's entry
    logic take_head;  // take the rotated head entry instead
    logic take_new;   // take the new message
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== design/pdrq_cell.sv =====
`default_nettype none
module pdrq_cell
  import pdrq_pkg::*;
#(
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  wire logic                  clk,
  input  wire cell_ctrl_t            ctrl,
  // new message
  input  wire logic [31:0]           new_tag,
  input  wire logic [1:0]            new_qos,
  input  wire logic                  new_retain,
  input  wire logic                  new_crit,
  input  wire logic [TIME_BITS-1:0]  new_due,
  // rotated head entry
  input  wire logic [31:0]           head_tag,
  input  wire logic [1:0]            head_qos,
  input  wire logic                  head_retain,
  input  wire logic                  head_crit,
  input  wire logic [TIME_BITS-1:0]  head_due,
  input  wire logic [TRIES_BITS-1:0] head_tries,
  // right-hand neighbor
  input  wire logic [31:0]           nb_tag,
  input  wire logic [1:0]            nb_qos,
  input  wire logic                  nb_retain,
  input  wire logic                  nb_crit,
  input  wire logic [TIME_BITS-1:0]  nb_due,
  input  wire logic [TRIES_BITS-1:0] nb_tries,
  // held entry
  output logic [31:0]                q_tag,
  output logic [1:0]                 q_qos,
  output logic                       q_retain,
  output logic                       q_crit,
  output logic [TIME_BITS-1:0]       q_due,
  output logic [TRIES_BITS-1:0]      q_tries
);

  logic [31:0]           tag_r;
  logic [1:0]            qos_r;
  logic                  retain_r;
  logic                  crit_r;
  logic [TIME_BITS-1:0]  due_r;
  logic [TRIES_BITS-1:0] tries_r;

  // entry load: new message, rotated head or neighbor
  always_ff @(posedge clk) begin
    if (ctrl.take_new) begin
      tag_r    <= new_tag;
      qos_r    <= new_qos;
      retain_r <= new_retain;
      crit_r   <= new_crit;
      due_r    <= new_due;
      tries_r  <= '0;
    end else if (ctrl.shift && ctrl.take_head) begin
      tag_r    <= head_tag;
      qos_r    <= head_qos;
      retain_r <= head_retain;
      crit_r   <= head_crit;
      due_r    <= head_due;
      tries_r  <= head_tries;
    end else if (ctrl.shift) begin
      tag_r    <= nb_tag;
      qos_r    <= nb_qos;
      retain_r <= nb_retain;
      crit_r   <= nb_crit;
      due_r    <= nb_due;
      tries_r  <= nb_tries;
    end
  end

  assign q_tag    = tag_r;
  assign q_qos    = qos_r;
  assign q_retain = retain_r;
  assign q_crit   = crit_r;
  assign q_due    = due_r;
  assign q_tries  = tries_r;

endmodule
`default_nettype wire

// ===== design/priority_drop_retry_queue_core.sv =====
`default_nettype none
// Ordered retry queue of QUEUE_DEPTH messages held in a row of cells that
// rotate through slot 0. An enqueue that is rejected or sent direct answers
// in the cycle after start; a queued message is answered from the append
// state, after an eviction pass over the held entries if the queue is full.
// A tick rotates the whole queue once, one entry a cycle while no refused
// attempt holds it in the backoff state, where the backoff doubles at most
// 20 times. Results come out one per cycle as they are found, each on
// out_valid for a single cycle; the receiver cannot stall, so it must take
// every word. busy is high while an item is at work.
module priority_drop_retry_queue_core
  import pdrq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int TIME_BITS   = DEF_TIME_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // command
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 in_func,
  input  wire logic [31:0]          in_message_tag,
  input  wire logic [1:0]           in_qos_level,
  input  wire logic                 in_retain_flag,
  input  wire logic                 in_critical_flag,
  input  wire logic [15:0]          in_payload_length,
  input  wire logic                 in_topic_valid,
  input  wire logic                 in_direct_accepted,
  input  wire logic [TIME_BITS-1:0] in_now_time,
  input  wire logic                 in_link_up,
  input  wire logic [7:0]           in_accept_mask,
  // results
  output logic                      out_valid,
  output logic [2:0]                out_status,
  output logic [31:0]               out_entry_tag,
  output logic [1:0]                out_entry_qos,
  output logic                      out_entry_retain,
  output logic [8:0]                out_attempt_number,
  output logic                      out_was_accepted,
  output logic                      out_persist_needed,
  output logic [3:0]                out_queue_count,
  output logic                      out_last_result,
  // configuration
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // configuration registers
  logic [15:0] base_r;
  logic [19:0] max_r;

  // sequencer
  state_t state_r, state_nxt;

  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [CW-1:0]           rem_r;
  logic [3:0]              n_r;
  logic [TRIES_BITS-1:0]   k_r, tries_new_r;
  logic [BACKOFF_BITS-1:0] b_r;

  // latched command
  logic [31:0]          tag_r;
  logic [1:0]           qos_r;
  logic                 ret_r;
  logic                 crit_r;
  logic [TIME_BITS-1:0] now_r;
  logic [7:0]           mask_r;
  logic [2:0]           st_r;
  logic                 pers_r;
  logic                 dropped_r;
  logic                 allcrit_r;

  // pending attempt report
  logic                 pv_r;
  logic [31:0]          p_tag_r;
  logic [1:0]           p_qos_r;
  logic                 p_ret_r;
  logic [8:0]           p_att_r;
  logic                 p_acc_r;
  logic                 p_pers_r;
  logic [3:0]           p_cnt_r;

  // output word
  logic        out_valid_r;
  logic [2:0]  o_status_r;
  logic [31:0] o_tag_r;
  logic [1:0]  o_qos_r;
  logic        o_ret_r;
  logic [8:0]  o_att_r;
  logic        o_acc_r;
  logic        o_pers_r;
  logic [3:0]  o_cnt_r;
  logic        o_last_r;

  // cell row
  cell_ctrl_t            cctrl [QUEUE_DEPTH];
  logic [31:0]           c_tag [QUEUE_DEPTH];
  logic [1:0]            c_qos [QUEUE_DEPTH];
  logic                  c_ret [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] c_crit;
  logic [TIME_BITS-1:0]  c_due [QUEUE_DEPTH];
  logic [TRIES_BITS-1:0] c_tries [QUEUE_DEPTH];

  // head rewrite data
  logic [TIME_BITS-1:0]  hd_due;
  logic [TRIES_BITS-1:0] hd_tries;

  // control
  logic accept, enq_reject, full, allcrit_now, too_large;
  logic due_ok, att, acc, evict_drop, bo_more, bo_done;
  logic shift, reinsert, drop, append, last_step;
  logic [BACKOFF_BITS-1:0] b_cap;
  logic [TIME_BITS:0]      due_sum;
  logic [TIME_BITS-1:0]    due_new;
  logic [TRIES_BITS-1:0]   tries_inc;
  logic [2:0]              rej_status;

  // configuration port
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    case (paddr[2])
      REG_BASE: prdata = {16'd0, base_r};
      REG_MAX:  prdata = {12'd0, max_r};
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
      max_r  <= MAX_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_BASE) begin
        base_r <= pwdata[15:0];
      end else begin
        max_r <= pwdata[19:0];
      end
    end
  end

  // enqueue checks
  assign accept      = start && !busy;
  assign full        = (cnt_r >= CW'(QUEUE_DEPTH));
  assign allcrit_now = &c_crit;
  assign too_large   = (in_payload_length >= PAYLOAD_LIMIT);
  assign enq_reject  = !in_topic_valid || too_large || in_direct_accepted ||
                       (full && allcrit_now && !in_critical_flag);

  always_comb begin
    if (!in_topic_valid) begin
      rej_status = ST_INVALID;
    end else if (too_large) begin
      rej_status = ST_TOO_LARGE;
    end else if (in_direct_accepted) begin
      rej_status = ST_DIRECT;
    end else begin
      rej_status = ST_FULL;
    end
  end

  // head evaluation and backoff unit
  assign due_ok    = (now_r >= c_due[0]);
  assign att       = (state_r == S_TICK) && due_ok && !n_r[3];
  assign acc       = mask_r[n_r[2:0]];
  assign tries_inc = (c_tries[0] == '1) ? c_tries[0] : c_tries[0] + 1'b1;
  assign bo_more   = (k_r < tries_new_r) && (b_r < {1'b0, max_r}) && (b_r != '0);
  assign bo_done   = (state_r == S_BACKOFF) && !bo_more;
  assign b_cap     = (b_r > {1'b0, max_r}) ? {1'b0, max_r} : b_r;
  assign due_sum   = {1'b0, now_r} + (TIME_BITS + 1)'(b_cap);
  assign due_new   = due_sum[TIME_BITS] ? '1 : due_sum[TIME_BITS-1:0];
  assign hd_due    = bo_done ? due_new : c_due[0];
  assign hd_tries  = bo_done ? tries_new_r : c_tries[0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_func) begin
            if (in_link_up && cnt_r != '0) state_nxt = S_TICK;
          end else if (!enq_reject) begin
            state_nxt = full ? S_EVICT : S_APPEND;
          end
        end
      end
      S_EVICT: begin
        if (last_step) state_nxt = S_APPEND;
      end
      S_APPEND: state_nxt = S_IDLE;
      S_TICK: begin
        if (att && !acc) begin
          state_nxt = S_BACKOFF;
        end else if (last_step) begin
          state_nxt = S_FLUSH;
        end
      end
      S_BACKOFF: begin
        if (bo_done) state_nxt = (rem_r == CW'(1)) ? S_FLUSH : S_TICK;
      end
      S_FLUSH: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs: row movement
  always_comb begin
    evict_drop = 1'b0;
    shift      = 1'b0;
    drop       = 1'b0;
    append     = 1'b0;
    case (state_r)
      S_EVICT: begin
        evict_drop = !dropped_r && (!c_crit[0] || allcrit_r);
        shift      = 1'b1;
        drop       = evict_drop;
      end
      S_APPEND: append = 1'b1;
      S_TICK: begin
        shift = !(att && !acc);
        drop  = att && acc;
      end
      S_BACKOFF: shift = bo_done;
      default: shift = 1'b0;
    endcase
  end

  assign reinsert  = shift && !drop;
  assign last_step = shift && (rem_r == CW'(1));
  assign busy      = (state_r != S_IDLE);

  always_comb begin
    cnt_nxt = cnt_r;
    if (drop) begin
      cnt_nxt = cnt_r - 1'b1;
    end else if (append) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  // cell row, slot 0 is the head
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam int NB = (i == QUEUE_DEPTH - 1) ? i : i + 1;

    assign cctrl[i].shift     = shift;
    assign cctrl[i].take_head = reinsert && (cnt_r == CW'(i + 1));
    assign cctrl[i].take_new  = append && (cnt_r == CW'(i));

    pdrq_cell #(
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk         (clk),
      .ctrl        (cctrl[i]),
      .new_tag     (tag_r),
      .new_qos     (qos_r),
      .new_retain  (ret_r),
      .new_crit    (crit_r),
      .new_due     (now_r),
      .head_tag    (c_tag[0]),
      .head_qos    (c_qos[0]),
      .head_retain (c_ret[0]),
      .head_crit   (c_crit[0]),
      .head_due    (hd_due),
      .head_tries  (hd_tries),
      .nb_tag      (c_tag[NB]),
      .nb_qos      (c_qos[NB]),
      .nb_retain   (c_ret[NB]),
      .nb_crit     (c_crit[NB]),
      .nb_due      (c_due[NB]),
      .nb_tries    (c_tries[NB]),
      .q_tag       (c_tag[i]),
      .q_qos       (c_qos[i]),
      .q_retain    (c_ret[i]),
      .q_crit      (c_crit[i]),
      .q_due       (c_due[i]),
      .q_tries     (c_tries[i])
    );
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      pv_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= 1'b0;
      if (accept) begin
        pv_r <= 1'b0;
        if (!in_func && enq_reject) out_valid_r <= 1'b1;
      end
      if (state_r == S_APPEND) out_valid_r <= 1'b1;
      if (att) begin
        pv_r <= 1'b1;
        if (pv_r) out_valid_r <= 1'b1;
      end
      if (state_r == S_FLUSH && pv_r) out_valid_r <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // command latch
    if (accept) begin
      tag_r     <= in_message_tag;
      qos_r     <= in_qos_level;
      ret_r     <= in_retain_flag;
      crit_r    <= in_critical_flag;
      now_r     <= in_now_time;
      mask_r    <= in_accept_mask;
      st_r      <= full ? ST_EVICTED : ST_QUEUED;
      pers_r    <= 1'b0;
      dropped_r <= 1'b0;
      allcrit_r <= allcrit_now;
      rem_r     <= cnt_r;
      n_r       <= '0;
    end
    if (shift) rem_r <= rem_r - 1'b1;
    if (evict_drop) begin
      dropped_r <= 1'b1;
      pers_r    <= c_crit[0];
    end
    // attempt capture
    if (att) begin
      n_r      <= n_r + 1'b1;
      p_tag_r  <= c_tag[0];
      p_qos_r  <= c_qos[0];
      p_ret_r  <= c_ret[0];
      p_att_r  <= {1'b0, c_tries[0]} + 9'd1;
      p_acc_r  <= acc;
      p_pers_r <= acc && c_crit[0];
      p_cnt_r  <= 4'(acc ? cnt_r - 1'b1 : cnt_r);
      tries_new_r <= tries_inc;
      b_r      <= BACKOFF_BITS'(base_r);
      k_r      <= '0;
    end
    // backoff doubling
    if (state_r == S_BACKOFF && bo_more) begin
      b_r <= {b_r[BACKOFF_BITS-2:0], 1'b0};
      k_r <= k_r + 1'b1;
    end
    // output word
    if (accept) begin
      o_status_r <= rej_status;
      o_tag_r    <= '0;
      o_qos_r    <= '0;
      o_ret_r    <= 1'b0;
      o_att_r    <= '0;
      o_acc_r    <= 1'b0;
      o_pers_r   <= 1'b0;
      o_cnt_r    <= 4'(cnt_r);
      o_last_r   <= 1'b1;
    end else if (state_r == S_APPEND) begin
      o_status_r <= st_r;
      o_tag_r    <= '0;
      o_qos_r    <= '0;
      o_ret_r    <= 1'b0;
      o_att_r    <= '0;
      o_acc_r    <= 1'b0;
      o_pers_r   <= pers_r || crit_r;
      o_cnt_r    <= 4'(cnt_r + 1'b1);
      o_last_r   <= 1'b1;
    end else if (att || state_r == S_FLUSH) begin
      o_status_r <= ST_QUEUED;
      o_tag_r    <= p_tag_r;
      o_qos_r    <= p_qos_r;
      o_ret_r    <= p_ret_r;
      o_att_r    <= p_att_r;
      o_acc_r    <= p_acc_r;
      o_pers_r   <= p_pers_r;
      o_cnt_r    <= p_cnt_r;
      o_last_r   <= (state_r == S_FLUSH);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = o_status_r;
  assign out_entry_tag      = o_tag_r;
  assign out_entry_qos      = o_qos_r;
  assign out_entry_retain   = o_ret_r;
  assign out_attempt_number = o_att_r;
  assign out_was_accepted   = o_acc_r;
  assign out_persist_needed = o_pers_r;
  assign out_queue_count    = o_cnt_r;
  assign out_last_result    = o_last_r;

`ifndef SYNTHESIS
  // fill level never passes the depth
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  // a tick with the link down gives nothing and leaves the block idle
  a_tick_down: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_func && !in_link_up |=> !out_valid && !busy)
    else $error("tick with link down produced work");

  // accepted attempts are always reported as attempt words
  a_acc_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_was_accepted |-> out_status == ST_QUEUED && out_attempt_number != 9'd0)
    else $error("accepted word with bad status");

  // the pending report is always flushed before going idle
  a_flush: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FLUSH && pv_r |=> out_valid && out_last_result)
    else $error("pending report lost");
`endif

endmodule
`default_nettype wire
